>>> hdl/utf8sd_pkg.sv
// ----------------------------------------------------------------------------
// utf8sd_pkg
// Shared types and byte-class constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

    // result kinds
    typedef enum logic [1:0] {
        KIND_CODE = 2'd0,
        KIND_BAD  = 2'd1,
        KIND_END  = 2'd2
    } t_kind;

    localparam int CODE_W = 21;
    localparam int CNT_W  = 16;

    // lead byte classes: tag under mask, and payload mask
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_TAG   = 8'hC0;
    localparam logic [7:0] LEAD2_BITS  = 8'h1F;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_TAG   = 8'hE0;
    localparam logic [7:0] LEAD3_BITS  = 8'h0F;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_TAG   = 8'hF0;
    localparam logic [7:0] LEAD4_BITS  = 8'h07;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_TAG    = 8'h80;
    localparam logic [7:0] CONT_BITS   = 8'h3F;

    // one result item
    typedef struct packed {
        t_kind              kind;
        logic [CODE_W-1:0]  code_value;
        logic [CNT_W-1:0]   char_count;
        logic               run_last;
    } t_result;

    // sequence state carried between bytes
    typedef struct packed {
        logic [CODE_W-1:0]  partial_code;
        logic [1:0]         bytes_due;
    } t_seq_state;

    // results produced by one byte, handed to the output queue
    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

>>> hdl/utf8_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// UTF-8 byte stream decoder with per-string codepoint indexing.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_byte_in) takes one string byte
//   per transfer; a zero byte ends the current string.
//   Output channel (o_out_valid / i_out_ready) delivers results: a decoded
//   codepoint, an invalid-sequence mark, or an end-of-string item carrying
//   the total count. o_run_last marks the last result of a byte.
//   Each byte yields zero, one or two results.
//   Results are registered in the result queue when their byte is taken.
//   One byte per cycle while bytes yield at most one result each and the
//   receiver takes every result; a byte with two results can hold off the
//   next byte, set by the single output port of the three-entry result queue.
//   Reset clears the pending sequence, the item count and the queue.
//   When the receiver stalls, up to three results are held and o_in_ready
//   drops once fewer than two entries are free.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top #(
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_byte_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [20:0] o_code_value,
    output logic [15:0] o_char_count,
    output logic        o_run_last
);
    import utf8sd_pkg::*;

    t_seq_state            r_state;
    t_seq_state            n_state;
    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] n_count;
    t_push                 push;
    t_result               head;
    logic                  in_xfer;

    assign in_xfer = i_in_valid && o_in_ready;

    // byte decode
    utf8sd_decode #(
        .COUNT_BITS (COUNT_BITS)
    ) u_decode (
        .i_byte_in (i_byte_in),
        .i_state   (r_state),
        .i_count   (r_count),
        .o_state   (n_state),
        .o_count   (n_count),
        .o_push    (push)
    );

    // sequence state and item count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_count <= '0;
        end else if (in_xfer) begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // result queue
    utf8sd_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_en   (in_xfer),
        .i_push      (push),
        .o_room      (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_head      (head)
    );

    assign o_kind       = head.kind;
    assign o_code_value = head.code_value;
    assign o_char_count = head.char_count;
    assign o_run_last   = head.run_last;

endmodule

>>> hdl/utf8sd_decode.sv
// ----------------------------------------------------------------------------
// utf8sd_decode
// Single-pass decode of one byte against the sequence state and item count.
// ----------------------------------------------------------------------------
module utf8sd_decode #(
    parameter int COUNT_BITS = 16
) (
    input  logic [7:0]               i_byte_in,
    input  utf8sd_pkg::t_seq_state   i_state,
    input  logic [COUNT_BITS-1:0]    i_count,
    output utf8sd_pkg::t_seq_state   o_state,
    output logic [COUNT_BITS-1:0]    o_count,
    output utf8sd_pkg::t_push        o_push
);
    import utf8sd_pkg::*;

    // saturating item counter step
    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        sat_inc = (&v) ? v : v + 1'b1;
    endfunction

    logic                  is_cont;
    logic                  pend;
    logic                  bad_first;
    logic [COUNT_BITS-1:0] c1;
    logic [CODE_W-1:0]     shifted;
    t_result               lead_res;
    logic                  lead_emit;

    assign is_cont = (i_byte_in & CONT_MASK) == CONT_TAG;
    assign pend    = i_state.bytes_due != 2'd0;
    assign shifted = {i_state.partial_code[CODE_W-7:0], i_byte_in[5:0]};

    always_comb begin
        o_state   = i_state;
        o_count   = i_count;
        o_push    = '0;
        bad_first = 1'b0;
        c1        = i_count;
        lead_res  = '0;
        lead_emit = 1'b0;

        if (pend && is_cont) begin
            // continuation byte: shift in six bits
            o_state.partial_code = shifted;
            o_state.bytes_due    = i_state.bytes_due - 2'd1;
            if (i_state.bytes_due == 2'd1) begin
                o_push.num             = 2'd1;
                o_push.res0.kind       = KIND_CODE;
                o_push.res0.code_value = shifted;
                o_push.res0.char_count = CNT_W'(i_count);
                o_state.partial_code   = '0;
                o_count                = sat_inc(i_count);
            end
        end else begin
            // broken sequence: report it, then treat the byte as a lead
            if (pend) begin
                bad_first            = 1'b1;
                o_push.res0.kind     = KIND_BAD;
                o_push.res0.char_count = CNT_W'(i_count);
                c1                   = sat_inc(i_count);
                o_state.partial_code = '0;
                o_state.bytes_due    = 2'd0;
            end
            o_count = c1;

            // lead byte classification
            if (i_byte_in == 8'd0) begin
                lead_emit           = 1'b1;
                lead_res.kind       = KIND_END;
                lead_res.char_count = CNT_W'(c1);
                o_count             = '0;
            end else if (i_byte_in < ASCII_LIMIT) begin
                lead_emit           = 1'b1;
                lead_res.kind       = KIND_CODE;
                lead_res.code_value = CODE_W'(i_byte_in);
                lead_res.char_count = CNT_W'(c1);
                o_count             = sat_inc(c1);
            end else if ((i_byte_in & LEAD2_MASK) == LEAD2_TAG) begin
                o_state.partial_code = CODE_W'(i_byte_in & LEAD2_BITS);
                o_state.bytes_due    = 2'd1;
            end else if ((i_byte_in & LEAD3_MASK) == LEAD3_TAG) begin
                o_state.partial_code = CODE_W'(i_byte_in & LEAD3_BITS);
                o_state.bytes_due    = 2'd2;
            end else if ((i_byte_in & LEAD4_MASK) == LEAD4_TAG) begin
                o_state.partial_code = CODE_W'(i_byte_in & LEAD4_BITS);
                o_state.bytes_due    = 2'd3;
            end else begin
                lead_emit           = 1'b1;
                lead_res.kind       = KIND_BAD;
                lead_res.char_count = CNT_W'(c1);
                o_count             = sat_inc(c1);
            end

            // place the lead result behind any broken-sequence result
            if (bad_first && lead_emit) begin
                o_push.num  = 2'd2;
                o_push.res1 = lead_res;
            end else if (bad_first) begin
                o_push.num = 2'd1;
            end else if (lead_emit) begin
                o_push.num  = 2'd1;
                o_push.res0 = lead_res;
            end
        end

        // flag the last result of this byte
        if (o_push.num == 2'd2) begin
            o_push.res1.run_last = 1'b1;
        end else if (o_push.num == 2'd1) begin
            o_push.res0.run_last = 1'b1;
        end
    end

endmodule

>>> hdl/utf8sd_outq.sv
// ----------------------------------------------------------------------------
// utf8sd_outq
// Three-entry result queue: takes up to two results per cycle, sends one.
// ----------------------------------------------------------------------------
module utf8sd_outq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push_en,
    input  utf8sd_pkg::t_push    i_push,
    output logic                 o_room,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output utf8sd_pkg::t_result  o_head
);
    import utf8sd_pkg::*;

    localparam int DEPTH = 3;

    t_result    r_entry [DEPTH];
    t_result    n_entry [DEPTH];
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic [1:0] push_num;
    logic [1:0] base;
    logic       pop;

    assign o_out_valid = r_count != 2'd0;
    assign o_head      = r_entry[0];
    assign pop         = o_out_valid && i_out_ready;
    // room for a worst-case byte (two results) without counting on a pop
    assign o_room      = r_count <= 2'd1;
    assign push_num    = i_push_en ? i_push.num : 2'd0;
    assign base        = r_count - {1'b0, pop};

    // shift out on transfer, then append new results
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            if (pop && k < DEPTH - 1) begin
                n_entry[k] = r_entry[k + 1];
            end else begin
                n_entry[k] = r_entry[k];
            end
            if (push_num != 2'd0 && 2'(k) == base) begin
                n_entry[k] = i_push.res0;
            end
            if (push_num == 2'd2 && 2'(k) == base + 2'd1) begin
                n_entry[k] = i_push.res1;
            end
        end
        n_count = base + push_num;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DEPTH; k++) begin
            r_entry[k] <= n_entry[k];
        end
    end

    // never append past the last entry
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_num != 2'd0) |-> (r_count <= 2'd1))
        else $error("result queue overflow");

    // a result not flagged last is always followed by its partner
    a_pair_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !o_head.run_last) |=> o_out_valid)
        else $error("second result of a byte missing");

    // a transfer with nothing pushed drains exactly one entry
    a_drain_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && push_num == 2'd0) |=> (r_count == $past(r_count) - 2'd1))
        else $error("queue count mismatch after transfer");

endmodule
